[rtl/core/md5_pkg.sv]
// Shared types, constants and round tables for the MD5 digest unit.
// Depends on nothing; md5_message_digest_unit uses it by scoped names.
package md5_pkg;

    // Input beat: one message byte and its flags.
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_md5_in;

    // Output beat: one digest word.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_md5_out;

    localparam logic [31:0] MD5_INIT_A = 32'h67452301;
    localparam logic [31:0] MD5_INIT_B = 32'hefcdab89;
    localparam logic [31:0] MD5_INIT_C = 32'h98badcfe;
    localparam logic [31:0] MD5_INIT_D = 32'h10325476;
    localparam logic [7:0]  MD5_PAD_MARK = 8'h80;
    localparam logic [5:0]  MD5_LEN_POS = 6'd56;
    localparam logic [4:0]  MD5_LEN_WORD = 5'd14;
    localparam logic [4:0]  MD5_BLOCK_WORDS = 5'd16;

    // Additive constant of each step (the integer parts of scaled sines).
    function automatic logic [31:0] md5_sine(input logic [5:0] step);
        logic [31:0] k;
        case (step)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Left rotate amount: four per round, chosen by the step's low two bits.
    function automatic logic [4:0] md5_shift(input logic [5:0] step);
        logic [4:0] s;
        case ({step[5:4], step[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;
            4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;
            4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Block word consumed by a step; all arithmetic is modulo 16.
    function automatic logic [3:0] md5_msg_index(input logic [5:0] step);
        logic [3:0] j;
        logic [3:0] g;
        j = step[3:0];
        case (step[5:4])
            2'd0:    g = j;
            2'd1:    g = {j[1:0], 2'b00} + j + 4'd1;
            2'd2:    g = {j[2:0], 1'b0} + j + 4'd5;
            default: g = {j[0], 3'b000} - j;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

endpackage

[rtl/core/md5_message_digest_unit.sv]
// MD5 digest unit: byte-wide input, block memory, one-step-per-cycle compression.
// Depends on md5_pkg (types, initial chaining values, step tables).
//
// Each input beat carries at most one message byte; a byte beat that does not
// complete a 64-byte block is written to the block memory. The sixty-fourth byte
// starts a compression that holds the input off while it issues the first read
// of the 16-word block memory, runs 64 steps through the single round unit (the
// memory read for the next step overlaps the current one), and folds the result
// into the chaining words. An end-of-message beat then writes the pad mark, zeros
// each word after the mark's word up to word 13 and writes the two length words
// before one compression. When fewer than nine bytes of room remain in the block,
// the zeros run to word 15 instead, a compression follows, and the fresh block is
// zeroed up to word 13 before its length words and its own compression. The
// digest then moves into the output buffer once that is empty, and leaves as
// four beats, word A first; input for the next message is taken while these
// beats drain, and a second end of message waits until the buffer is empty.
module md5_message_digest_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  md5_pkg::t_md5_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output md5_pkg::t_md5_out o_out_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_ROUND  = 4'd2;
    localparam logic [3:0] S_ADD    = 4'd3;
    localparam logic [3:0] S_MARK   = 4'd4;
    localparam logic [3:0] S_ZERO   = 4'd5;
    localparam logic [3:0] S_LEN_LO = 4'd6;
    localparam logic [3:0] S_LEN_HI = 4'd7;
    localparam logic [3:0] S_DONE   = 4'd8;

    // What follows a compression.
    localparam logic [1:0] AFTER_BYTE  = 2'd0;
    localparam logic [1:0] AFTER_MARK  = 2'd1;
    localparam logic [1:0] AFTER_PAD   = 2'd2;
    localparam logic [1:0] AFTER_FINAL = 2'd3;

    logic [3:0]  r_state;
    logic [1:0]  r_after;
    logic [5:0]  r_fill;
    logic [60:0] r_count;
    logic [4:0]  r_wptr;
    logic        r_lenblk;
    logic [5:0]  r_ridx;

    logic [31:0] r_chain_a, r_chain_b, r_chain_c, r_chain_d;
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [31:0] r_ak;

    logic [31:0] r_block_mem [16];
    logic [31:0] r_rdata;

    logic [31:0] r_dig [4];
    logic        r_out_valid;
    logic [1:0]  r_oidx;

    logic        in_acc;
    logic        out_acc;
    logic        load_digest;
    logic [3:0]  mem_be;
    logic [3:0]  mem_waddr;
    logic [31:0] mem_wdata;
    logic [3:0]  mem_raddr;
    logic [5:0]  rd_step;
    logic [31:0] k_next;
    logic [31:0] f_val;
    logic [31:0] z_val;
    logic [31:0] n_b;
    logic [4:0]  zero_lim;

    assign in_acc      = i_in_valid & ~o_in_stall;
    assign out_acc     = r_out_valid & ~i_out_stall;
    assign load_digest = (r_state == S_DONE) && !r_out_valid;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign zero_lim    = r_lenblk ? md5_pkg::MD5_LEN_WORD : md5_pkg::MD5_BLOCK_WORDS;

    always_comb begin
        o_out_data.digest_word = r_dig[r_oidx];
        o_out_data.word_index  = r_oidx;
        o_out_data.last_word   = (r_oidx == 2'd3);
    end

    // Round datapath. The read for the next step is issued while this one runs.
    assign rd_step   = (r_state == S_ROUND) ? r_ridx + 6'd1 : 6'd0;
    assign mem_raddr = md5_pkg::md5_msg_index(rd_step);
    assign k_next    = md5_pkg::md5_sine(rd_step);

    always_comb begin
        case (r_ridx[5:4])
            2'd0:    f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f_val = (r_d & r_b) | (~r_d & r_c);
            2'd2:    f_val = r_b ^ r_c ^ r_d;
            default: f_val = r_c ^ (r_b | ~r_d);
        endcase
    end

    // r_ak already holds a + K for this step.
    assign z_val = r_ak + f_val + r_rdata;
    assign n_b   = r_b + md5_pkg::md5_rotl(z_val, md5_pkg::md5_shift(r_ridx));

    // Block memory write port: byte lanes for message bytes and the pad mark.
    always_comb begin
        mem_be    = 4'b0000;
        mem_waddr = r_fill[5:2];
        mem_wdata = 32'h0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_in_data.has_byte) begin
                    mem_be    = 4'b0001 << r_fill[1:0];
                    mem_wdata = {4{i_in_data.msg_byte}};
                end
            end
            S_MARK: begin
                // The mark byte, and zeros in the lanes above it.
                mem_be    = 4'b1111 << r_fill[1:0];
                mem_wdata = {24'h0, md5_pkg::MD5_PAD_MARK} << {r_fill[1:0], 3'b000};
            end
            S_ZERO: begin
                mem_waddr = r_wptr[3:0];
                if (r_wptr < zero_lim) begin
                    mem_be = 4'b1111;
                end
            end
            S_LEN_LO: begin
                mem_waddr = 4'd14;
                mem_be    = 4'b1111;
                mem_wdata = {r_count[28:0], 3'b000};
            end
            S_LEN_HI: begin
                mem_waddr = 4'd15;
                mem_be    = 4'b1111;
                mem_wdata = r_count[60:29];
            end
            default: begin
                mem_be = 4'b0000;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (mem_be[k]) begin
                r_block_mem[mem_waddr][k*8 +: 8] <= mem_wdata[k*8 +: 8];
            end
        end
        r_rdata <= r_block_mem[mem_raddr];
    end

    // Working variables of the compression.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_a  <= r_chain_a;
            r_b  <= r_chain_b;
            r_c  <= r_chain_c;
            r_d  <= r_chain_d;
            r_ak <= r_chain_a + k_next;
        end else if (r_state == S_ROUND) begin
            r_a  <= r_d;
            r_b  <= n_b;
            r_c  <= r_b;
            r_d  <= r_c;
            r_ak <= r_d + k_next;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_after   <= AFTER_BYTE;
            r_fill    <= 6'd0;
            r_count   <= 61'd0;
            r_wptr    <= 5'd0;
            r_lenblk  <= 1'b0;
            r_ridx    <= 6'd0;
            r_chain_a <= md5_pkg::MD5_INIT_A;
            r_chain_b <= md5_pkg::MD5_INIT_B;
            r_chain_c <= md5_pkg::MD5_INIT_C;
            r_chain_d <= md5_pkg::MD5_INIT_D;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_data.has_byte) begin
                            r_fill  <= r_fill + 6'd1;
                            r_count <= r_count + 61'd1;
                        end
                        if (i_in_data.has_byte && r_fill == 6'd63) begin
                            r_state <= S_LOAD;
                            r_after <= i_in_data.end_of_message ? AFTER_MARK : AFTER_BYTE;
                        end else if (i_in_data.end_of_message) begin
                            r_state <= S_MARK;
                        end
                    end
                end
                S_LOAD: begin
                    r_ridx  <= 6'd0;
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_ridx <= r_ridx + 6'd1;
                    if (r_ridx == 6'd63) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_chain_a <= r_chain_a + r_a;
                    r_chain_b <= r_chain_b + r_b;
                    r_chain_c <= r_chain_c + r_c;
                    r_chain_d <= r_chain_d + r_d;
                    unique case (r_after)
                        AFTER_BYTE: r_state <= S_IDLE;
                        AFTER_MARK: r_state <= S_MARK;
                        AFTER_PAD: begin
                            r_wptr   <= 5'd0;
                            r_lenblk <= 1'b1;
                            r_state  <= S_ZERO;
                        end
                        default: r_state <= S_DONE;
                    endcase
                end
                S_MARK: begin
                    r_wptr   <= {1'b0, r_fill[5:2]} + 5'd1;
                    r_lenblk <= (r_fill < md5_pkg::MD5_LEN_POS);
                    r_state  <= S_ZERO;
                end
                S_ZERO: begin
                    if (r_wptr < zero_lim) begin
                        r_wptr <= r_wptr + 5'd1;
                    end else if (r_lenblk) begin
                        r_state <= S_LEN_LO;
                    end else begin
                        // No room for the length: compress and pad a fresh block.
                        r_after <= AFTER_PAD;
                        r_state <= S_LOAD;
                    end
                end
                S_LEN_LO: begin
                    r_state <= S_LEN_HI;
                end
                S_LEN_HI: begin
                    r_after <= AFTER_FINAL;
                    r_state <= S_LOAD;
                end
                S_DONE: begin
                    if (load_digest) begin
                        r_chain_a <= md5_pkg::MD5_INIT_A;
                        r_chain_b <= md5_pkg::MD5_INIT_B;
                        r_chain_c <= md5_pkg::MD5_INIT_C;
                        r_chain_d <= md5_pkg::MD5_INIT_D;
                        r_fill    <= 6'd0;
                        r_count   <= 61'd0;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Digest buffer; it drains one beat at a time while new input is taken.
    always_ff @(posedge i_clk) begin
        if (load_digest) begin
            r_dig[0] <= r_chain_a;
            r_dig[1] <= r_chain_b;
            r_dig[2] <= r_chain_c;
            r_dig[3] <= r_chain_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_oidx      <= 2'd0;
        end else if (load_digest) begin
            r_out_valid <= 1'b1;
            r_oidx      <= 2'd0;
        end else if (out_acc) begin
            r_oidx <= r_oidx + 2'd1;
            if (r_oidx == 2'd3) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The step counter advances by one each cycle of a compression.
    a_step_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND && r_ridx != 6'd63)
        |=> (r_state == S_ROUND && r_ridx == $past(r_ridx) + 6'd1))
        else $error("compression step counter skipped");

    // The sixty-fourth byte always starts a compression.
    a_full_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.has_byte && r_fill == 6'd63) |=> (r_state == S_LOAD))
        else $error("full block not compressed");

    // A pending digest is never overwritten by the next one.
    a_digest_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid) |=> (r_state == S_DONE && $stable(r_dig[3])))
        else $error("digest buffer overwritten before drained");

    // A new digest starts with a fresh message state.
    a_fresh_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> (r_fill == 6'd0 && r_count == 61'd0 && r_oidx == 2'd0
                                && r_chain_a == md5_pkg::MD5_INIT_A))
        else $error("message state not cleared after digest");

endmodule

[test/tb_top.sv]
// Self-checking testbench for md5_message_digest_unit: directed messages with known
// digests, then random messages checked against a bit-exact MD5 predictor.
// Depends on md5_pkg for the beat types and on the RTL of the digest unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 130;
    localparam int DRAIN_CYCLES = 300;

    localparam logic [127:0] DIGEST_EMPTY = 128'hd98c1dd4_04b2008f_980980e9_7e42f8ec;
    localparam logic [127:0] DIGEST_A     = 128'hb975c10c_a8b6f1c0_e299c331_61267769;
    localparam logic [127:0] DIGEST_ABC   = 128'h98500190_b04fd23c_7d3f96d6_727fe128;

    localparam logic [0:63][31:0] SINE_K = {
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [0:15][4:0] ROT_AMT = {
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    localparam logic [31:0] CHAIN_A0 = 32'h67452301;
    localparam logic [31:0] CHAIN_B0 = 32'hefcdab89;
    localparam logic [31:0] CHAIN_C0 = 32'h98badcfe;
    localparam logic [31:0] CHAIN_D0 = 32'h10325476;

    typedef struct packed {
        md5_pkg::t_md5_in beat;
        logic             known;
        logic [127:0]     digest;
    } dir_row_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    md5_pkg::t_md5_in  i_in_data = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    md5_pkg::t_md5_out o_out_data;

    // Predictor state.
    logic [31:0] chain_a = CHAIN_A0;
    logic [31:0] chain_b = CHAIN_B0;
    logic [31:0] chain_c = CHAIN_C0;
    logic [31:0] chain_d = CHAIN_D0;
    logic [7:0]  block_bytes [64];
    int          fill_pos = 0;
    logic [60:0] msg_bytes = '0;

    md5_pkg::t_md5_out digest_q [$];
    md5_pkg::t_md5_out want;
    int                mismatch_count = 0;
    int                stall_left = 0;
    int                quiet_left = 0;

    md5_message_digest_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic dir_row_t dir_row(input logic [7:0] b, input logic h, input logic e,
                                         input logic k, input logic [127:0] d);
        return {b, h, e, k, d};
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic void md5_compress();
        logic [31:0] a, b, c, d, f, z, t;
        logic [31:0] m [16];
        int          i, g, r, s;
        for (i = 0; i < 16; i++) begin
            m[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
        end
        a = chain_a;
        b = chain_b;
        c = chain_c;
        d = chain_d;
        for (i = 0; i < 64; i++) begin
            r = i / 16;
            case (r)
                0: begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            s = ROT_AMT[r * 4 + i % 4];
            z = a + f + SINE_K[i] + m[g];
            t = d;
            d = c;
            c = b;
            b = b + ((z << s) | (z >> (32 - s)));
            a = t;
        end
        chain_a += a;
        chain_b += b;
        chain_c += c;
        chain_d += d;
    endfunction

    // Takes one accepted input beat; returns 1 with the digest {A,B,C,D} when it ends
    // the message.
    function automatic bit md5_absorb(input md5_pkg::t_md5_in beat, output logic [127:0] dig);
        logic [63:0] bit_len;
        int          k;
        dig = '0;
        if (beat.has_byte) begin
            block_bytes[fill_pos] = beat.msg_byte;
            fill_pos = (fill_pos + 1) % 64;
            msg_bytes = msg_bytes + 61'd1;
            if (fill_pos == 0) begin
                md5_compress();
            end
        end
        if (!beat.end_of_message) begin
            return 1'b0;
        end
        block_bytes[fill_pos] = 8'h80;
        fill_pos++;
        // No room left for the length: it goes into an extra block.
        if (fill_pos > 56) begin
            while (fill_pos < 64) begin
                block_bytes[fill_pos] = 8'h00;
                fill_pos++;
            end
            md5_compress();
            fill_pos = 0;
        end
        while (fill_pos < 56) begin
            block_bytes[fill_pos] = 8'h00;
            fill_pos++;
        end
        bit_len = {msg_bytes, 3'b000};
        for (k = 0; k < 8; k++) begin
            block_bytes[56 + k] = bit_len[8*k +: 8];
        end
        md5_compress();
        dig = {chain_a, chain_b, chain_c, chain_d};
        chain_a = CHAIN_A0;
        chain_b = CHAIN_B0;
        chain_c = CHAIN_C0;
        chain_d = CHAIN_D0;
        fill_pos = 0;
        msg_bytes = '0;
        return 1'b1;
    endfunction

    // Drives one input beat after a random gap and records its expected digest words.
    task automatic push_beat(input md5_pkg::t_md5_in beat, input bit calm, input bit known,
                             input logic [127:0] typed);
        int                gap;
        logic [127:0]      dig;
        md5_pkg::t_md5_out exp_word;
        gap = calm ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        if (md5_absorb(beat, dig)) begin
            if (known) begin
                dig = typed;
            end
            for (int k = 0; k < 4; k++) begin
                exp_word.digest_word = dig[127 - 32*k -: 32];
                exp_word.word_index  = 2'(k);
                exp_word.last_word   = (k == 3);
                digest_q.push_back(exp_word);
            end
        end
    endtask

    // Output stall pattern: bursts of stall, with quiet windows mixed in.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (quiet_left > 0) begin
            i_out_stall <= 1'b0;
            quiet_left  <= quiet_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            if ($urandom_range(0, 5) == 0) begin
                quiet_left <= $urandom_range(30, 150);
            end else begin
                stall_left <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest beat, actual word %h index %0d last %0b",
                         $time, o_out_data.digest_word, o_out_data.word_index,
                         o_out_data.last_word);
                mismatch_count++;
            end else begin
                want = digest_q.pop_front();
                if (o_out_data.digest_word !== want.digest_word ||
                    o_out_data.word_index !== want.word_index ||
                    o_out_data.last_word !== want.last_word) begin
                    $display("%0t: digest beat mismatch, expected %h/%0d/%0b actual %h/%0d/%0b",
                             $time, want.digest_word, want.word_index, want.last_word,
                             o_out_data.digest_word, o_out_data.word_index,
                             o_out_data.last_word);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        dir_row_t dir_rows [$];
        md5_pkg::t_md5_in beat;
        int  sent, msg_no, msg_len, long_a_at, long_b_at;
        bit  calm, joined;

        // End without a byte (empty message), noise beats, byte and end together, and
        // back-to-back ends that must start again from the initial chaining words.
        dir_rows.push_back(dir_row(8'h5a, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY));
        dir_rows.push_back(dir_row(8'hff, 1'b0, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(8'h61, 1'b1, 1'b1, 1'b1, DIGEST_A));
        dir_rows.push_back(dir_row(8'h61, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(8'h62, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(8'h00, 1'b0, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(8'h63, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(8'ha5, 1'b0, 1'b1, 1'b1, DIGEST_ABC));
        dir_rows.push_back(dir_row(8'h00, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(8'hff, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(8'h80, 1'b1, 1'b0, 1'b0, '0));
        dir_rows.push_back(dir_row(8'h7f, 1'b1, 1'b1, 1'b0, '0));
        dir_rows.push_back(dir_row(8'h00, 1'b1, 1'b1, 1'b0, '0));
        dir_rows.push_back(dir_row(8'hff, 1'b1, 1'b1, 1'b0, '0));
        dir_rows.push_back(dir_row(8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY));
        dir_rows.push_back(dir_row(8'h01, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY));

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            push_beat(dir_rows[n].beat, 1'b0, dir_rows[n].known, dir_rows[n].digest);
        end

        // Random messages, mostly short. Two long ones reach the padding corners: one
        // leaves too little room for the length, one fills the block with the marker
        // or with its last byte.
        long_a_at = $urandom_range(0, 3);
        long_b_at = $urandom_range(4, 8);
        sent = 0;
        msg_no = 0;
        while (sent < RANDOM_ITEMS || msg_no <= long_b_at) begin
            if (msg_no == long_a_at) begin
                msg_len = $urandom_range(56, 62);
            end else if (msg_no == long_b_at) begin
                msg_len = $urandom_range(63, 64);
            end else begin
                msg_len = $urandom_range(0, 12);
            end
            calm = ($urandom_range(0, 3) == 0);
            joined = (msg_len > 0) && ($urandom_range(0, 1) == 1);
            for (int k = 0; k < msg_len; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    beat = '{msg_byte: 8'($urandom), has_byte: 1'b0, end_of_message: 1'b0};
                    push_beat(beat, calm, 1'b0, '0);
                end
                beat = '{msg_byte: 8'($urandom), has_byte: 1'b1,
                         end_of_message: joined && (k == msg_len - 1)};
                push_beat(beat, calm, 1'b0, '0);
                sent++;
            end
            if (!joined) begin
                beat = '{msg_byte: 8'($urandom), has_byte: 1'b0, end_of_message: 1'b1};
                push_beat(beat, calm, 1'b0, '0);
                sent++;
            end
            msg_no++;
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (digest_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule
